/* sv/fmvs_pkg.sv */
// Shared types and constants of the feature-match view scorer.
`default_nettype none
package fmvs_pkg;

  localparam int DIST_W    = 16;
  localparam int AMB_W     = 17;
  localparam int SUM_W     = 35;
  localparam int CNT_W     = 13;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_AMBIGUITY = 2'd1;

  localparam logic [DIST_W-1:0] MAX_DISTANCE_RST  = 16'd256;
  localparam logic [AMB_W-1:0]  MAX_AMBIGUITY_RST = 17'd52429;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam int CNT_FIELD_MAX = 8191;
  localparam int TERM_CAP_INT  = 100;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } fmvs_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } fmvs_div_stat_t;

endpackage
`default_nettype wire

/* sv/fmvs_div.sv */
// Radix-2 restoring divider: 2^(8+TERM_FRAC_BITS) / distance, one quotient bit per cycle.
`default_nettype none
module fmvs_div import fmvs_pkg::*; #(
  parameter int TERM_FRAC_BITS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [DIST_W-1:0]           divisor_i,
  output fmvs_div_stat_t                   stat_o,
  output logic [TERM_FRAC_BITS+8:0]        quot_o
);

  localparam int QW = TERM_FRAC_BITS + 9;
  localparam int CW = $clog2(QW);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [DIST_W:0]   rem_q, rem_d;
  logic [QW-1:0]     quot_q, quot_d;
  logic [DIST_W-1:0] divisor_q, divisor_d;

  logic [DIST_W:0]   rem_sh;
  logic              fits;

  always_comb begin
    rem_sh    = {rem_q[DIST_W-1:0], (cnt_q == '0)};
    fits      = rem_sh >= {1'b0, divisor_q};
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    quot_d    = quot_q;
    divisor_d = divisor_q;
    if (start_i) begin
      busy_d    = 1'b1;
      cnt_d     = '0;
      rem_d     = '0;
      divisor_d = divisor_i;
    end else if (busy_q) begin
      rem_d  = fits ? (rem_sh - {1'b0, divisor_q}) : rem_sh;
      quot_d = {quot_q[QW-2:0], fits};
      cnt_d  = cnt_q + CW'(1);
      if (cnt_q == CW'(QW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    quot_q    <= quot_d;
    divisor_q <= divisor_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;

endmodule
`default_nettype wire

/* sv/feature_match_view_scorer.sv */
// Top level of the feature-match view scorer: sequencer, score state and output register.
//
// Use: feed the matches of each view, sorted by rising distance, one word per match on
// the input channel (in_valid_i / in_stall_o). Mark the word that closes a view with
// last_of_view_i and the word that closes a model with last_of_model_i; a word with
// match_present_i low only carries end marks. A word with an end mark produces one
// result word on the output channel (out_valid_o / out_stall_i); other words produce none.
// A scored match waits in the divide step while the restoring divider forms the
// reciprocal one bit per cycle; a skipped or stopped match or an end-only word goes
// from the idle step straight to the final step. in_stall_o is high while a word is in
// work. The result register holds one word: the block keeps accepting while it waits,
// and holds in its final step only when a new result is due and the previous one is still
// stalled. Reset clears the scores, counts and flags and loads the registers with their
// defaults (distance limit 1.0, ambiguity limit about 0.8). The user must write registers
// through cfg_we_i / cfg_idx_i / cfg_data_i while idle; the block does not enforce this.
`default_nettype none
module feature_match_view_scorer import fmvs_pkg::*; #(
  parameter int MAX_MATCHES    = 4096,
  parameter int TERM_FRAC_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [DIST_W-1:0]    match_distance_i,
  input  wire logic [AMB_W-1:0]     match_ambiguity_i,
  input  wire logic                 match_present_i,
  input  wire logic                 last_of_view_i,
  input  wire logic                 last_of_model_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [SUM_W-1:0]          view_score_o,
  output logic [CNT_W-1:0]          good_matches_o,
  output logic [SUM_W-1:0]          model_score_o,
  output logic                      model_done_o
);

  localparam int QW = TERM_FRAC_BITS + 9;
  localparam int CNT_LIMIT_INT = (MAX_MATCHES < CNT_FIELD_MAX) ? MAX_MATCHES : CNT_FIELD_MAX;
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(CNT_LIMIT_INT);
  localparam logic [QW-1:0] TERM_CAP = QW'(TERM_CAP_INT) << TERM_FRAC_BITS;

  fmvs_state_e state_q, state_d;

  logic [DIST_W-1:0] max_dist_q;
  logic [AMB_W-1:0]  max_amb_q;

  logic [SUM_W-1:0]  view_sum_q, view_sum_d;
  logic [CNT_W-1:0]  view_cnt_q, view_cnt_d;
  logic              view_stop_q, view_stop_d;
  logic [SUM_W-1:0]  model_best_q, model_best_d;

  logic              add_q, add_d;
  logic              stop_q, stop_d;
  logic              eov_q, eov_d;
  logic              eom_q, eom_d;

  logic              out_valid_q, out_valid_d;
  logic [SUM_W-1:0]  out_view_q, out_view_d;
  logic [CNT_W-1:0]  out_cnt_q, out_cnt_d;
  logic [SUM_W-1:0]  out_model_q, out_model_d;
  logic              out_done_q, out_done_d;

  fmvs_div_stat_t    div_stat;
  logic [QW-1:0]     div_quot;
  logic              div_start;

  logic              in_accept;
  logic              score;
  logic [QW-1:0]     term;
  logic [SUM_W:0]    sum_ext;
  logic [SUM_W-1:0]  sum_new;
  logic [CNT_W-1:0]  cnt_new;
  logic [SUM_W-1:0]  best_new;
  logic              has_result;
  logic              out_free;

  fmvs_div #(
    .TERM_FRAC_BITS(TERM_FRAC_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (match_distance_i),
    .stat_o    (div_stat),
    .quot_o    (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dist_q <= MAX_DISTANCE_RST;
      max_amb_q  <= MAX_AMBIGUITY_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_DISTANCE:  max_dist_q <= cfg_data_i[DIST_W-1:0];
        CFG_MAX_AMBIGUITY: max_amb_q  <= cfg_data_i[AMB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_accept  = in_valid_i && (state_q == ST_IDLE);
    score      = match_present_i && !view_stop_q && (match_ambiguity_i < max_amb_q);
    term       = (div_quot > TERM_CAP) ? TERM_CAP : div_quot;
    sum_ext    = {1'b0, view_sum_q} + {{(SUM_W + 1 - QW){1'b0}}, term};
    sum_new    = view_sum_q;
    cnt_new    = view_cnt_q;
    if (add_q) begin
      sum_new = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
      cnt_new = (view_cnt_q < CNT_LIMIT) ? view_cnt_q + CNT_W'(1) : view_cnt_q;
    end
    best_new   = (sum_new > model_best_q) ? sum_new : model_best_q;
    has_result = eov_q || eom_q;
    out_free   = !out_valid_q || !out_stall_i;

    state_d      = state_q;
    div_start    = 1'b0;
    add_d        = add_q;
    stop_d       = stop_q;
    eov_d        = eov_q;
    eom_d        = eom_q;
    view_sum_d   = view_sum_q;
    view_cnt_d   = view_cnt_q;
    view_stop_d  = view_stop_q;
    model_best_d = model_best_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_view_d   = out_view_q;
    out_cnt_d    = out_cnt_q;
    out_model_d  = out_model_q;
    out_done_d   = out_done_q;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          stop_d    = score && (match_distance_i > max_dist_q);
          add_d     = score && !(match_distance_i > max_dist_q);
          eov_d     = last_of_view_i;
          eom_d     = last_of_model_i;
          div_start = add_d;
          state_d   = add_d ? ST_DIV : ST_FIN;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!has_result || out_free) begin
          view_sum_d  = sum_new;
          view_cnt_d  = cnt_new;
          view_stop_d = view_stop_q || stop_q;
          if (has_result) begin
            out_valid_d = 1'b1;
            out_view_d  = '0;
            out_cnt_d   = '0;
            out_model_d = '0;
            out_done_d  = 1'b0;
          end
          if (eov_q) begin
            out_view_d   = sum_new;
            out_cnt_d    = cnt_new;
            model_best_d = best_new;
            view_sum_d   = '0;
            view_cnt_d   = '0;
            view_stop_d  = 1'b0;
          end
          if (eom_q) begin
            out_model_d  = eov_q ? best_new : model_best_q;
            out_done_d   = 1'b1;
            model_best_d = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      view_sum_q   <= '0;
      view_cnt_q   <= '0;
      view_stop_q  <= 1'b0;
      model_best_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      view_sum_q   <= view_sum_d;
      view_cnt_q   <= view_cnt_d;
      view_stop_q  <= view_stop_d;
      model_best_q <= model_best_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    add_q       <= add_d;
    stop_q      <= stop_d;
    eov_q       <= eov_d;
    eom_q       <= eom_d;
    out_view_q  <= out_view_d;
    out_cnt_q   <= out_cnt_d;
    out_model_q <= out_model_d;
    out_done_q  <= out_done_d;
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign view_score_o   = out_view_q;
  assign good_matches_o = out_cnt_q;
  assign model_score_o  = out_model_q;
  assign model_done_o   = out_done_q;

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide step");

  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    view_cnt_q <= CNT_LIMIT)
    else $error("good-match count passed its limit");

  a_new_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> ($past(state_q) == ST_FIN))
    else $error("result word loaded outside the final step");

  a_div_idle_in_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |-> !div_stat.busy)
    else $error("divider still busy in the final step");

endmodule
`default_nettype wire

/* dv/fmvs_tb_pkg.sv */
// Score prediction and result checking for the feature-match view scorer testbench.
`default_nettype none
package fmvs_tb_pkg;
  import fmvs_pkg::*;

  localparam int MATCH_LIMIT = 4096;
  localparam int TERM_BITS   = 16;
  localparam int COUNT_CAP   = (MATCH_LIMIT < CNT_FIELD_MAX) ? MATCH_LIMIT : CNT_FIELD_MAX;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [AMB_W-1:0]  amb;
    logic              present;
    logic              end_view;
    logic              end_model;
  } match_word_t;

  typedef struct packed {
    logic [SUM_W-1:0] view_score;
    logic [CNT_W-1:0] good;
    logic [SUM_W-1:0] model_score;
    logic             done;
  } score_word_t;

  class score_board;
    logic [DIST_W-1:0] dist_limit;
    logic [AMB_W-1:0]  amb_limit;
    logic [SUM_W-1:0]  view_sum;
    logic [CNT_W-1:0]  good_count;
    logic              view_stopped;
    logic [SUM_W-1:0]  model_best;
    score_word_t       due_q[$];
    int                errors;
    int                results_seen;

    function new();
      dist_limit   = MAX_DISTANCE_RST;
      amb_limit    = MAX_AMBIGUITY_RST;
      view_sum     = '0;
      good_count   = '0;
      view_stopped = 1'b0;
      model_best   = '0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void set_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_MAX_DISTANCE:  dist_limit = data[DIST_W-1:0];
        CFG_MAX_AMBIGUITY: amb_limit  = data[AMB_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [SUM_W-1:0] recip_term(logic [DIST_W-1:0] d);
      logic [SUM_W-1:0] cap;
      logic [SUM_W-1:0] q;
      cap = SUM_W'(TERM_CAP_INT) << TERM_BITS;
      if (d == '0) return cap;
      q = (SUM_W'(1) << (8 + TERM_BITS)) / SUM_W'(d);
      return (q > cap) ? cap : q;
    endfunction

    function void note_word(match_word_t w);
      logic [SUM_W:0] total;
      score_word_t    r;
      if (w.present && !view_stopped && w.amb < amb_limit) begin
        if (w.distance > dist_limit) begin
          view_stopped = 1'b1;
        end else begin
          total    = {1'b0, view_sum} + {1'b0, recip_term(w.distance)};
          view_sum = total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
          if (good_count < CNT_W'(COUNT_CAP)) good_count++;
        end
      end
      if (!w.end_view && !w.end_model) return;
      r = '0;
      if (w.end_view) begin
        r.view_score = view_sum;
        r.good       = good_count;
        if (view_sum > model_best) model_best = view_sum;
        view_sum     = '0;
        good_count   = '0;
        view_stopped = 1'b0;
      end
      if (w.end_model) begin
        r.model_score = model_best;
        r.done        = 1'b1;
        model_best    = '0;
      end
      due_q = {due_q, r};
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR: %s", msg);
    endtask

    task check_result(score_word_t got);
      score_word_t want;
      results_seen++;
      if (due_q.size() == 0) begin
        report($sformatf("result %0d arrived with none due", results_seen));
        return;
      end
      want = due_q.pop_front();
      if (got.view_score !== want.view_score || got.good !== want.good ||
          got.model_score !== want.model_score || got.done !== want.done) begin
        report($sformatf("result %0d got/want: view %0d/%0d good %0d/%0d model %0d/%0d done %0b/%0b",
                         results_seen, got.view_score, want.view_score, got.good, want.good,
                         got.model_score, want.model_score, got.done, want.done));
      end
    endtask
  endclass

endpackage
`default_nettype wire

/* dv/tb_top.sv */
// Top-level testbench of the feature-match view scorer: clock, reset, drivers and checks.
`default_nettype none
module tb_top import fmvs_pkg::*, fmvs_tb_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 64;
  localparam int PHASES        = 7;
  localparam int PHASE_WORDS   = 230;
  localparam int SAT_WORDS     = 300;

  logic                 clk_i;
  logic                 rst_ni            = 1'b0;
  logic                 cfg_we_i          = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i         = CFG_MAX_DISTANCE;
  logic [CFG_W-1:0]     cfg_data_i        = '0;
  logic                 in_valid_i        = 1'b0;
  logic                 in_stall_o;
  logic [DIST_W-1:0]    match_distance_i  = '0;
  logic [AMB_W-1:0]     match_ambiguity_i = '0;
  logic                 match_present_i   = 1'b0;
  logic                 last_of_view_i    = 1'b0;
  logic                 last_of_model_i   = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i       = 1'b0;
  logic [SUM_W-1:0]     view_score_o;
  logic [CNT_W-1:0]     good_matches_o;
  logic [SUM_W-1:0]     model_score_o;
  logic                 model_done_o;

  score_board  sb = new();
  score_word_t seen_word;
  bit          calm        = 1'b0;
  int          words_sent  = 0;
  int unsigned cycle_count = 0;

  feature_match_view_scorer #(
    .MAX_MATCHES   (MATCH_LIMIT),
    .TERM_FRAC_BITS(TERM_BITS)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .match_distance_i (match_distance_i),
    .match_ambiguity_i(match_ambiguity_i),
    .match_present_i  (match_present_i),
    .last_of_view_i   (last_of_view_i),
    .last_of_model_i  (last_of_model_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .view_score_o     (view_score_o),
    .good_matches_o   (good_matches_o),
    .model_score_o    (model_score_o),
    .model_done_o     (model_done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("feature_match_view_scorer: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      seen_word.view_score  = view_score_o;
      seen_word.good        = good_matches_o;
      seen_word.model_score = model_score_o;
      seen_word.done        = model_done_o;
      sb.check_result(seen_word);
    end
    out_stall_i <= !calm && ($urandom_range(0, 99) < 21);
  end

  function automatic match_word_t make_word(int distance, int amb, bit present, bit end_view,
                                            bit end_model);
    match_word_t w;
    w.distance  = DIST_W'(distance);
    w.amb       = AMB_W'(amb);
    w.present   = present;
    w.end_view  = end_view;
    w.end_model = end_model;
    return w;
  endfunction

  task automatic send_word(input match_word_t w);
    if (!calm && $urandom_range(0, 99) < 21) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    match_distance_i  <= w.distance;
    match_ambiguity_i <= w.amb;
    match_present_i   <= w.present;
    last_of_view_i    <= w.end_view;
    last_of_model_i   <= w.end_model;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_word(w);
    words_sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_limits(input logic [CFG_W-1:0] dist_val,
                                input logic [CFG_W-1:0] amb_val, input bit spare);
    logic [CFG_W-1:0] junk;
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_MAX_DISTANCE;
    cfg_data_i <= dist_val;
    @(posedge clk_i);
    sb.set_limit(CFG_MAX_DISTANCE, dist_val);
    cfg_idx_i  <= CFG_MAX_AMBIGUITY;
    cfg_data_i <= amb_val;
    @(posedge clk_i);
    sb.set_limit(CFG_MAX_AMBIGUITY, amb_val);
    if (spare) begin
      junk       = CFG_W'($urandom);
      cfg_idx_i  <= CFG_IDX_SPARE_A;
      cfg_data_i <= junk;
      @(posedge clk_i);
      sb.set_limit(CFG_IDX_SPARE_A, junk);
      cfg_idx_i  <= CFG_IDX_SPARE_B;
      cfg_data_i <= ~junk;
      @(posedge clk_i);
      sb.set_limit(CFG_IDX_SPARE_B, ~junk);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 4)) begin
      send_word(make_word($urandom, $urandom, $urandom_range(0, 1),
                          $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0));
    end
  endtask

  task automatic send_model();
    int nviews;
    int nm;
    int lim;
    int span;
    int d;
    int amb;
    int amb_lim;
    lim     = int'(sb.dist_limit);
    amb_lim = int'(sb.amb_limit);
    span    = lim / 3 + 2;
    nviews  = $urandom_range(0, 3);
    if (nviews == 0) begin
      send_word(make_word($urandom, $urandom, 1'b0, $urandom_range(0, 1), 1'b1));
      return;
    end
    for (int v = 0; v < nviews; v++) begin
      nm = $urandom_range(0, 10);
      if (nm == 0) begin
        send_word(make_word($urandom, $urandom, 1'b0, 1'b1, v == nviews - 1));
      end else begin
        d = $urandom_range(0, lim / 2 + 1);
        for (int m = 0; m < nm; m++) begin
          if (amb_lim != 0 && $urandom_range(0, 99) < 80) amb = $urandom_range(0, amb_lim - 1);
          else amb = $urandom_range(0, 131071);
          send_word(make_word(d, amb, 1'b1, m == nm - 1, (m == nm - 1) && (v == nviews - 1)));
          d = d + $urandom_range(0, span);
          if (d > 65535) d = 65535;
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset limits: distance 1.0, ambiguity about 0.8
    send_word(make_word(0, 0, 1'b0, 1'b0, 1'b1));
    send_word(make_word(0, 0, 1'b0, 1'b1, 1'b0));
    send_word(make_word(65535, 131071, 1'b0, 1'b0, 1'b0));
    send_word(make_word(0, 0, 1'b1, 1'b0, 1'b0));
    send_word(make_word(1, 100, 1'b1, 1'b0, 1'b0));
    send_word(make_word(128, 52428, 1'b1, 1'b0, 1'b0));
    send_word(make_word(200, 52429, 1'b1, 1'b0, 1'b0));
    send_word(make_word(200, 131071, 1'b1, 1'b0, 1'b0));
    send_word(make_word(256, 0, 1'b1, 1'b0, 1'b1));
    send_word(make_word(257, 0, 1'b1, 1'b0, 1'b0));
    send_word(make_word(300, 0, 1'b1, 1'b0, 1'b0));
    send_word(make_word(0, 0, 1'b0, 1'b1, 1'b0));
    send_word(make_word(256, 0, 1'b1, 1'b1, 1'b1));
    send_word(make_word(65535, 65536, 1'b1, 1'b1, 1'b1));
    send_word(make_word(3, 1, 1'b1, 1'b1, 1'b0));
    send_word(make_word(257, 0, 1'b1, 1'b1, 1'b1));
    send_word(make_word(255, 65535, 1'b1, 1'b1, 1'b1));

    // one long view of capped zero-distance terms
    for (int i = 0; i < SAT_WORDS; i++) begin
      send_word(make_word(0, 0, 1'b1, i == SAT_WORDS - 1, i == SAT_WORDS - 1));
    end
    send_word(make_word(512, 0, 1'b1, 1'b1, 1'b1));
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       program_limits(17'd0, 17'd65536, 1'b0);
        1:       program_limits(17'd32768, 17'd1, 1'b1);
        2:       program_limits(17'h1FFFF, 17'h1FFFF, 1'b0);
        3:       program_limits(17'd512, 17'd0, 1'b0);
        4:       program_limits(CFG_W'($urandom_range(0, 32768)),
                                CFG_W'($urandom_range(0, 65536)), 1'b0);
        5:       program_limits(17'd256, 17'd52429, 1'b0);
        default: program_limits(CFG_W'($urandom), CFG_W'($urandom), 1'b1);
      endcase
      calm = (p == 2);
      send_word(make_word(int'(sb.dist_limit), 0, 1'b1, 1'b1, 1'b1));
      words_sent = 0;
      while (words_sent < PHASE_WORDS) begin
        if ($urandom_range(0, 99) < 15) send_noise();
        else send_model();
        if ($urandom_range(0, 199) == 0) drain_results();
      end
      send_word(make_word(0, 0, 1'b0, 1'b1, 1'b1));
      drain_results();
    end
    calm = 1'b0;

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("feature_match_view_scorer: match");
    end else begin
      $display("feature_match_view_scorer: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* feature_match_view_scorer.f */
sv/fmvs_pkg.sv
sv/fmvs_div.sv
sv/feature_match_view_scorer.sv
dv/fmvs_tb_pkg.sv
dv/tb_top.sv
